FILE: sv/tlssni_pkg.sv
`default_nettype none

package tlssni_pkg;

    localparam int POSITION_BITS = 20;

    localparam logic [7:0]  REC_HANDSHAKE = 8'h16;
    localparam int          PREFIX_LEN    = 43;
    localparam logic [15:0] SNI_TYPE      = 16'h0000;
    localparam int          SNI_HDR_LEN   = 5;
    localparam int          EXT_HDR_LEN   = 4;

    typedef enum logic [3:0] {
        PH_TYPE,
        PH_PREFIX,
        PH_SID_LEN,
        PH_SID,
        PH_CS_HI,
        PH_CS_LO,
        PH_CS,
        PH_COMP_LEN,
        PH_COMP,
        PH_EL_HI,
        PH_EL_LO,
        PH_EXT_HDR,
        PH_EXT_BODY,
        PH_SNI_HDR,
        PH_NAME,
        PH_IDLE
    } t_phase;

    typedef struct packed {
        logic [7:0] name_byte;
        logic       name_valid;
        logic       name_end;
        logic       done_res;
        logic       found;
    } t_result;

endpackage

`default_nettype wire

FILE: sv/tlssni_ifs.sv
`default_nettype none

interface tlssni_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       is_last;

    modport source (output valid, output data_byte, output is_last, input ready);
    modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

interface tlssni_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] name_byte;
    logic       name_valid;
    logic       name_end;
    logic       done_res;
    logic       found;

    modport source (output valid, output name_byte, output name_valid, output name_end,
                    output done_res, output found, input ready);
    modport sink   (input valid, input name_byte, input name_valid, input name_end,
                    input done_res, input found, output ready);
endinterface

`default_nettype wire

FILE: sv/tlssni_parser.sv
`default_nettype none

module tlssni_parser (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_step,
    input  wire logic [7:0]         i_data_byte,
    input  wire logic               i_is_last,
    output tlssni_pkg::t_result     o_result
);
    import tlssni_pkg::*;

    localparam int PB = POSITION_BITS;
    localparam logic [PB-1:0] POS_MAX = {PB{1'b1}};

    t_phase         r_phase,    n_phase;
    logic [PB-1:0]  r_pos,      n_pos;
    logic [16:0]    r_skip,     n_skip;
    logic [PB-1:0]  r_ext_end,  n_ext_end;
    logic [7:0]     r_hi,       n_hi;
    logic [15:0]    r_name_rem, n_name_rem;
    logic           r_found,    n_found;

    logic [15:0]    w_len;
    logic [PB-1:0]  w_pos_inc;
    logic [PB:0]    w_end_sum;
    logic           w_hdr_past;
    logic           w_sni_past;
    logic           w_name_past;
    logic           w_valid;
    logic           w_end;

    always_comb begin
        w_len       = {r_hi, i_data_byte};
        w_pos_inc   = (r_pos == POS_MAX) ? r_pos : r_pos + 1'b1;
        w_end_sum   = {1'b0, w_pos_inc} + {{(PB+1-16){1'b0}}, w_len};
        w_hdr_past  = ({1'b0, r_pos} + (PB+1)'(EXT_HDR_LEN)) > {1'b0, r_ext_end};
        w_sni_past  = ({1'b0, r_pos} + (PB+1)'(SNI_HDR_LEN + 1)) > {1'b0, r_ext_end};
        w_name_past = ({1'b0, r_pos} + (PB+1)'(1) + {{(PB+1-16){1'b0}}, w_len})
                      > {1'b0, r_ext_end};
    end

    always_comb begin
        n_phase    = r_phase;
        n_skip     = r_skip;
        n_ext_end  = r_ext_end;
        n_hi       = r_hi;
        n_name_rem = r_name_rem;
        n_found    = r_found;
        n_pos      = w_pos_inc;
        w_valid    = 1'b0;
        w_end      = 1'b0;

        case (r_phase)
            PH_TYPE: begin
                if (i_data_byte != REC_HANDSHAKE) begin
                    n_phase = PH_IDLE;
                end else begin
                    n_skip  = 17'(PREFIX_LEN - 1);
                    n_phase = PH_PREFIX;
                end
            end
            PH_PREFIX, PH_SID, PH_CS, PH_COMP: begin
                n_skip = r_skip - 1'b1;
                if (n_skip == '0) begin
                    if (r_phase == PH_PREFIX) begin
                        n_phase = PH_SID_LEN;
                    end else if (r_phase == PH_SID) begin
                        n_phase = PH_CS_HI;
                    end else if (r_phase == PH_CS) begin
                        n_phase = PH_COMP_LEN;
                    end else begin
                        n_phase = PH_EL_HI;
                    end
                end
            end
            PH_SID_LEN: begin
                if (i_data_byte == '0) begin
                    n_phase = PH_CS_HI;
                end else begin
                    n_skip  = {9'd0, i_data_byte};
                    n_phase = PH_SID;
                end
            end
            PH_CS_HI, PH_EL_HI: begin
                n_hi    = i_data_byte;
                n_phase = (r_phase == PH_CS_HI) ? PH_CS_LO : PH_EL_LO;
            end
            PH_CS_LO: begin
                if (w_len == '0) begin
                    n_phase = PH_COMP_LEN;
                end else begin
                    n_skip  = {1'b0, w_len};
                    n_phase = PH_CS;
                end
            end
            PH_COMP_LEN: begin
                if (i_data_byte == '0) begin
                    n_phase = PH_EL_HI;
                end else begin
                    n_skip  = {9'd0, i_data_byte};
                    n_phase = PH_COMP;
                end
            end
            PH_EL_LO: begin
                n_ext_end  = w_end_sum[PB] ? POS_MAX : w_end_sum[PB-1:0];
                n_phase    = PH_EXT_HDR;
                n_skip     = '0;
                n_name_rem = '0;
            end
            PH_EXT_HDR: begin
                if (r_skip == 17'd0) begin
                    if (w_hdr_past) begin
                        n_phase = PH_IDLE;
                    end else begin
                        n_hi   = i_data_byte;
                        n_skip = 17'd1;
                    end
                end else if (r_skip == 17'd1) begin
                    n_name_rem = (w_len == SNI_TYPE) ? 16'd1 : 16'd0;
                    n_skip     = 17'd2;
                end else if (r_skip == 17'd2) begin
                    n_hi   = i_data_byte;
                    n_skip = 17'd3;
                end else if (r_name_rem != '0) begin
                    if (w_sni_past) begin
                        n_phase = PH_IDLE;
                    end else begin
                        n_name_rem = '0;
                        n_skip     = '0;
                        n_phase    = PH_SNI_HDR;
                    end
                end else if (w_len == '0) begin
                    n_skip     = '0;
                    n_name_rem = '0;
                end else begin
                    n_skip  = {1'b0, w_len};
                    n_phase = PH_EXT_BODY;
                end
            end
            PH_EXT_BODY: begin
                n_skip = r_skip - 1'b1;
                if (n_skip == '0) begin
                    n_phase    = PH_EXT_HDR;
                    n_name_rem = '0;
                end
            end
            PH_SNI_HDR: begin
                if (r_skip >= 17'd4) begin
                    if (w_len == '0 || w_name_past) begin
                        n_phase = PH_IDLE;
                    end else begin
                        n_name_rem = w_len;
                        n_phase    = PH_NAME;
                    end
                end else begin
                    if (r_skip == 17'd3) begin
                        n_hi = i_data_byte;
                    end
                    n_skip = r_skip + 1'b1;
                end
            end
            PH_NAME: begin
                w_valid = 1'b1;
                if (r_name_rem <= 16'd1) begin
                    w_end      = 1'b1;
                    n_name_rem = '0;
                    n_found    = 1'b1;
                    n_phase    = PH_IDLE;
                end else begin
                    n_name_rem = r_name_rem - 1'b1;
                end
            end
            default: begin
            end
        endcase

        o_result.name_byte  = w_valid ? i_data_byte : 8'd0;
        o_result.name_valid = w_valid;
        o_result.name_end   = w_end;
        o_result.done_res   = i_is_last;
        o_result.found      = i_is_last & n_found;
    end

    // state returns to reset after the final byte of a buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_is_last)) begin
            r_phase    <= PH_TYPE;
            r_pos      <= '0;
            r_skip     <= '0;
            r_ext_end  <= '0;
            r_hi       <= '0;
            r_name_rem <= '0;
            r_found    <= 1'b0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_pos      <= n_pos;
            r_skip     <= n_skip;
            r_ext_end  <= n_ext_end;
            r_hi       <= n_hi;
            r_name_rem <= n_name_rem;
            r_found    <= n_found;
        end
    end

endmodule

`default_nettype wire

FILE: sv/tls_client_hello_sni_extractor.sv
`default_nettype none

// Extracts the server name from a TLS ClientHello fed one byte per transaction, with is_last
// marking the final byte of the buffer. Every input byte yields exactly one result: name bytes
// come out flagged by name_valid, name_end marks the last one, and the result for the final
// byte carries done_res with found set only if a complete, non-empty name from the first
// server_name extension fitted in the buffer. Throughput is one byte per clock while the
// output is not stalled by o_out.ready; each byte passes the input register, then the parser's
// combinational result into the result register; all parse state clears after the final byte.
module tls_client_hello_sni_extractor (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    tlssni_in_if.sink       i_in,
    tlssni_out_if.source    o_out
);
    import tlssni_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_out_valid;
    t_result    r_out;
    t_result    w_result;
    logic       w_move;

    assign w_move     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_move;

    tlssni_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_move),
        .i_data_byte (r_in_byte),
        .i_is_last   (r_in_last),
        .o_result    (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.data_byte;
            r_in_last <= i_in.is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_move) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out <= w_result;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.name_byte  = r_out.name_byte;
    assign o_out.name_valid = r_out.name_valid;
    assign o_out.name_end   = r_out.name_end;
    assign o_out.done_res   = r_out.done_res;
    assign o_out.found      = r_out.found;

    a_found_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.found |-> r_out.done_res)
        else $error("found without done_res");

    a_end_is_name: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.name_end |-> r_out.name_valid)
        else $error("name_end outside the name");

    a_byte_masked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.name_valid |-> r_out.name_byte == 8'd0)
        else $error("name_byte set on a non-name byte");

    a_load_on_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_move |=> r_out_valid)
        else $error("result register missed a transaction");

endmodule

`default_nettype wire
